// ===== sv/tpp_pkg.sv =====
// ----------------------------------------------------------------------------
// tpp_pkg
// Shared types and constants for the turtle pen plotter over a one-bit bitmap.
// ----------------------------------------------------------------------------
package tpp_pkg;

    localparam int GRID_SIZE = 32;
    localparam int COORD_W   = $clog2(GRID_SIZE);
    localparam int ROW_W     = 32;
    localparam int FUNC_W    = 4;
    localparam int DIST_W    = 6;

    localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(GRID_SIZE - 1);

    localparam logic [FUNC_W-1:0] CMD_PEN_DOWN  = 4'd1;
    localparam logic [FUNC_W-1:0] CMD_PEN_UP    = 4'd2;
    localparam logic [FUNC_W-1:0] CMD_TURN_BACK = 4'd3;
    localparam logic [FUNC_W-1:0] CMD_TURN_FWD  = 4'd4;
    localparam logic [FUNC_W-1:0] CMD_MOVE      = 4'd5;
    localparam logic [FUNC_W-1:0] CMD_PRINT     = 4'd6;

    typedef enum logic [1:0] {
        HEAD_RIGHT = 2'd0,
        HEAD_DOWN  = 2'd1,
        HEAD_LEFT  = 2'd2,
        HEAD_UP    = 2'd3
    } t_heading;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MARK,
        ST_PRINT
    } t_state;

    typedef struct packed {
        logic               rd_en;
        logic [COORD_W-1:0] rd_addr;
        logic               wr_en;
        logic [COORD_W-1:0] wr_addr;
        logic [ROW_W-1:0]   wr_data;
    } t_mem_req;

endpackage

// ===== sv/tpp_bitmap_mem.sv =====
// ----------------------------------------------------------------------------
// tpp_bitmap_mem
// Bitmap row store: one write and one registered read a cycle. A row-valid
// flop per row, cleared at reset, makes an unwritten row read as blank.
// ----------------------------------------------------------------------------
module tpp_bitmap_mem (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tpp_pkg::t_mem_req            i_req,
    output logic [tpp_pkg::ROW_W-1:0]    o_rd_data
);
    import tpp_pkg::*;

    logic [ROW_W-1:0]     r_mem [GRID_SIZE];
    logic [GRID_SIZE-1:0] r_valid;
    logic [ROW_W-1:0]     r_rd_data;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_valid[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== sv/turtle_pen_plotter_bitmap.sv =====
// ----------------------------------------------------------------------------
// turtle_pen_plotter_bitmap
// Turtle command interpreter drawing into a 32 x 32 one-bit bitmap held in a
// synchronous row memory; print streams the rows out one word each.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  command | i_valid, o_ready, i_func, i_distance     | in
//  row     | o_valid, i_ready, o_row_bits,            | out
//          | o_row_number, o_last_row                 |
//
//  Pen, turn, pen-up move and unused codes finish as they are accepted.
//  A pen-down move reads, ORs and writes back one row a cycle, then drains
//  its last write-back; a horizontal move marks one row, a vertical one each row.
//  Print reads one row a cycle when the output flows.
//  A stalled output word holds the print sequencer; reset clears the bitmap
//  at once through per-row valid flops, with no clearing pass.
// ----------------------------------------------------------------------------
module turtle_pen_plotter_bitmap (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [tpp_pkg::FUNC_W-1:0]     i_func,
    input  logic [tpp_pkg::DIST_W-1:0]     i_distance,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [tpp_pkg::ROW_W-1:0]      o_row_bits,
    output logic [tpp_pkg::COORD_W-1:0]    o_row_number,
    output logic                           o_last_row
);
    import tpp_pkg::*;

    t_state             r_state, n_state;
    t_heading           r_heading, n_heading;
    logic [COORD_W-1:0] r_pen_row, n_pen_row;
    logic [COORD_W-1:0] r_pen_col, n_pen_col;
    logic               r_pen_down, n_pen_down;
    logic [COORD_W-1:0] r_cur, n_cur;
    logic [COORD_W-1:0] r_hi, n_hi;
    logic [ROW_W-1:0]   r_mask, n_mask;
    logic               r_issuing, n_issuing;
    logic               r_wpend, n_wpend;
    logic [COORD_W-1:0] r_wrow, n_wrow;
    logic               r_out_vld, n_out_vld;
    logic [ROW_W-1:0]   r_row_bits, n_row_bits;
    logic [COORD_W-1:0] r_row_num, n_row_num;
    logic               r_last, n_last;

    t_mem_req           mem_req;
    logic [ROW_W-1:0]   rd_data;

    // move geometry
    logic               horiz, fwd, accept, out_free;
    logic [COORD_W-1:0] start, end_pos, lo, hi;
    logic [COORD_W+1:0] sum;
    logic [ROW_W-1:0]   range_mask;

    tpp_bitmap_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    always_comb begin
        horiz = (r_heading == HEAD_RIGHT) || (r_heading == HEAD_LEFT);
        fwd   = (r_heading == HEAD_RIGHT) || (r_heading == HEAD_DOWN);
        start = horiz ? r_pen_col : r_pen_row;
        sum   = {2'b00, start} + {1'b0, i_distance};
        if (fwd) begin
            end_pos = (sum > {2'b00, COORD_MAX}) ? COORD_MAX : sum[COORD_W-1:0];
        end else begin
            end_pos = (i_distance > {1'b0, start}) ? '0
                      : COORD_W'({1'b0, start} - i_distance);
        end
        lo = fwd ? start : end_pos;
        hi = fwd ? end_pos : start;
        range_mask = ({ROW_W{1'b1}} << lo) & ({ROW_W{1'b1}} >> (COORD_MAX - hi));
    end

    assign o_ready  = (r_state == ST_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_vld || i_ready;

    always_comb begin
        n_state    = r_state;
        n_heading  = r_heading;
        n_pen_row  = r_pen_row;
        n_pen_col  = r_pen_col;
        n_pen_down = r_pen_down;
        n_cur      = r_cur;
        n_hi       = r_hi;
        n_mask     = r_mask;
        n_issuing  = r_issuing;
        n_wpend    = 1'b0;
        n_wrow     = r_wrow;
        n_out_vld  = r_out_vld && !i_ready;
        n_row_bits = r_row_bits;
        n_row_num  = r_row_num;
        n_last     = r_last;

        mem_req.rd_en   = 1'b0;
        mem_req.rd_addr = r_cur;
        mem_req.wr_en   = r_wpend;
        mem_req.wr_addr = r_wrow;
        mem_req.wr_data = rd_data | r_mask;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_func)
                        CMD_PEN_DOWN:  n_pen_down = 1'b1;
                        CMD_PEN_UP:    n_pen_down = 1'b0;
                        CMD_TURN_BACK: n_heading  = t_heading'(r_heading + 2'd3);
                        CMD_TURN_FWD:  n_heading  = t_heading'(r_heading + 2'd1);
                        CMD_MOVE: begin
                            if (horiz) begin
                                n_pen_col = end_pos;
                                n_cur     = r_pen_row;
                                n_hi      = r_pen_row;
                                n_mask    = range_mask;
                            end else begin
                                n_pen_row = end_pos;
                                n_cur     = lo;
                                n_hi      = hi;
                                n_mask    = ROW_W'(1) << r_pen_col;
                            end
                            if (r_pen_down) begin
                                n_issuing = 1'b1;
                                n_state   = ST_MARK;
                            end
                        end
                        CMD_PRINT: begin
                            // fetch the top row now
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = '0;
                            n_cur           = '0;
                            n_state         = ST_PRINT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MARK: begin
                // read the next row while writing back the previous one
                if (r_issuing) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = r_cur;
                    n_wpend         = 1'b1;
                    n_wrow          = r_cur;
                    if (r_cur == r_hi) begin
                        n_issuing = 1'b0;
                    end else begin
                        n_cur = r_cur + 1'b1;
                    end
                end else if (!r_wpend) begin
                    n_state = ST_IDLE;
                end
            end
            ST_PRINT: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_row_bits = rd_data;
                    n_row_num  = r_cur;
                    n_last     = (r_cur == COORD_MAX);
                    if (r_cur == COORD_MAX) begin
                        n_state = ST_IDLE;
                    end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = r_cur + 1'b1;
                        n_cur           = r_cur + 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_heading  <= HEAD_RIGHT;
            r_pen_row  <= '0;
            r_pen_col  <= '0;
            r_pen_down <= 1'b0;
            r_issuing  <= 1'b0;
            r_wpend    <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_heading  <= n_heading;
            r_pen_row  <= n_pen_row;
            r_pen_col  <= n_pen_col;
            r_pen_down <= n_pen_down;
            r_issuing  <= n_issuing;
            r_wpend    <= n_wpend;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_hi       <= n_hi;
        r_mask     <= n_mask;
        r_wrow     <= n_wrow;
        r_row_bits <= n_row_bits;
        r_row_num  <= n_row_num;
        r_last     <= n_last;
    end

    assign o_valid      = r_out_vld;
    assign o_row_bits   = r_row_bits;
    assign o_row_number = r_row_num;
    assign o_last_row   = r_last;

    // read and write never touch the same row in one cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.rd_en && mem_req.wr_en |-> mem_req.rd_addr != mem_req.wr_addr)
        else $error("bitmap read and write hit the same row");

    a_last_is_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_row |-> o_row_number == COORD_MAX)
        else $error("last-row mark on a row other than the bottom one");

    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_row |=>
            !o_valid || o_row_number == COORD_W'($past(o_row_number) + 1'b1))
        else $error("print rows out of order");

    a_no_write_in_print: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_PRINT |-> !mem_req.wr_en)
        else $error("bitmap written during print");

endmodule
